[rtl/sh256_pkg.sv]
// Shared types, constants and round functions for the SHA-256 stream hasher.
`timescale 1ns / 1ps
package sh256_pkg;

	localparam int unsigned HASH_WORDS = 8;
	localparam int unsigned ROUNDS     = 64;
	localparam logic [5:0]  LEN_POS    = 6'd56;
	localparam logic [5:0]  LAST_BYTE  = 6'd63;
	localparam logic [5:0]  LAST_ROUND = 6'd63;
	localparam logic [2:0]  LAST_WORD  = 3'd7;
	localparam logic [7:0]  PAD_MARK   = 8'h80;

	localparam logic [31:0] K_TABLE [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] IV_TABLE [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	// Sequencer commands to the datapath
	typedef struct packed {
		logic       push;
		logic [7:0] push_data;
		logic       load;
		logic       round;
		logic [5:0] round_idx;
		logic       fold;
		logic       restart;
		logic [2:0] out_idx;
	} ctl_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

[rtl/sh256_if.sv]
// Valid/ready channel interfaces for message bytes and digest words.
`timescale 1ns / 1ps
interface sh256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       message_end;

	modport source (output valid, data_byte, byte_valid, message_end, input ready);
	modport sink   (input valid, data_byte, byte_valid, message_end, output ready);
endinterface

interface sh256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/sh256_ctrl.sv]
// Sequencer: byte intake, padding, round count and digest readout.
`timescale 1ns / 1ps
module sh256_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      in_data,
	input  logic            in_byte_valid,
	input  logic            in_end,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output sh256_pkg::ctl_t ctl
);
	import sh256_pkg::*;

	state_t      state_q, state_nxt;
	logic [5:0]  fill_q;
	logic [63:0] bitcnt_q;
	logic        mark_q;
	logic        len_q;
	logic        pad_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        in_acc;
	logic        out_acc;
	logic [7:0]  pad_val;
	logic [2:0]  len_sel;
	logic        is_len;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Padding byte: marker, zero fill, then the length most significant byte first
	assign is_len  = mark_q && (len_q || fill_q == LEN_POS);
	assign len_sel = LAST_WORD - fill_q[2:0];
	always_comb begin
		if (!mark_q) begin
			pad_val = PAD_MARK;
		end else if (!is_len) begin
			pad_val = 8'h00;
		end else begin
			pad_val = bitcnt_q[{len_sel, 3'b000} +: 8];
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_byte_valid && fill_q == LAST_BYTE) begin
						state_nxt = ST_ROUND;
					end else if (in_end) begin
						state_nxt = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (fill_q == LAST_BYTE) begin
					state_nxt = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rnd_q == LAST_ROUND) begin
					state_nxt = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (len_q) begin
					state_nxt = ST_OUT;
				end else if (pad_q) begin
					state_nxt = ST_PAD;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_acc && idx_q == LAST_WORD) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		ctl.push      = 1'b0;
		ctl.push_data = in_data;
		ctl.load      = 1'b0;
		ctl.round     = 1'b0;
		ctl.round_idx = rnd_q;
		ctl.fold      = 1'b0;
		ctl.restart   = 1'b0;
		ctl.out_idx   = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.push = in_acc && in_byte_valid;
				ctl.load = in_acc && in_byte_valid && fill_q == LAST_BYTE;
			end
			ST_PAD: begin
				ctl.push      = 1'b1;
				ctl.push_data = pad_val;
				ctl.load      = fill_q == LAST_BYTE;
			end
			ST_ROUND: ctl.round = 1'b1;
			ST_FOLD:  ctl.fold = 1'b1;
			ST_OUT: begin
				out_valid   = 1'b1;
				ctl.restart = out_acc && idx_q == LAST_WORD;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			bitcnt_q <= '0;
			mark_q   <= 1'b0;
			len_q    <= 1'b0;
			pad_q    <= 1'b0;
			rnd_q    <= '0;
			idx_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (ctl.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (state_q == ST_IDLE && in_acc) begin
				pad_q <= in_end;
				if (in_byte_valid) begin
					bitcnt_q <= bitcnt_q + 64'd8;
				end
			end
			if (state_q == ST_PAD) begin
				if (!mark_q) begin
					mark_q <= 1'b1;
				end else if (is_len) begin
					len_q <= 1'b1;
				end
			end
			if (ctl.round) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (out_acc) begin
				idx_q <= idx_q + 3'd1;
			end
			// Drop message state once the last word is taken
			if (ctl.restart) begin
				bitcnt_q <= '0;
				mark_q   <= 1'b0;
				len_q    <= 1'b0;
				pad_q    <= 1'b0;
			end
		end
	end

endmodule

[rtl/sh256_core.sv]
// Datapath: block buffer doubling as schedule window, round unit, chaining words.
`timescale 1ns / 1ps
module sh256_core (
	input  logic            clk,
	input  logic            arst_n,
	input  sh256_pkg::ctl_t ctl,
	output logic [31:0]     digest_word
);
	import sh256_pkg::*;

	logic [511:0] blk_q;
	logic [31:0]  v_q     [HASH_WORDS];
	logic [31:0]  chain_q [HASH_WORDS];
	logic [31:0]  w0, w1, w9, w14, w_new;
	logic [31:0]  t1, t2, ch, maj;

	// Word i of the window sits at blk_q[511-32*i -: 32]
	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];
	assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + big_sigma1(v_q[4]) + ch + K_TABLE[ctl.round_idx] + w0;
	assign t2  = big_sigma0(v_q[0]) + maj;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			blk_q <= {blk_q[503:0], ctl.push_data};
		end else if (ctl.round) begin
			blk_q <= {blk_q[479:0], w_new};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= chain_q;
		end else if (ctl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= IV_TABLE;
		end else if (ctl.restart) begin
			chain_q <= IV_TABLE;
		end else if (ctl.fold) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

	assign digest_word = chain_q[ctl.out_idx];

endmodule

[rtl/sha256_stream_hash.sv]
// Top level of the SHA-256 stream hasher.
//
//   channel | dir | payload                               | handshake
//   msg     | in  | data_byte, byte_valid, message_end    | valid/ready
//   digest  | out | digest_word, word_index, last_word    | valid/ready
//
// Message bytes are taken one per cycle while idle; the byte that fills a block starts a
// compression of 64 rounds through the single round unit, then a fold into the chain.
// Closing a message pads one byte per cycle (at most 72 bytes) and runs one or two
// compressions before the first digest word is offered; the eight words then go out
// one per accepted handshake.
// msg.ready is high only while idle; digest words hold until taken.
// Reset loads the initial chaining values and clears the counters at once.
`timescale 1ns / 1ps
module sha256_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	sh256_in_if.sink    msg,
	sh256_out_if.source digest
);
	import sh256_pkg::*;

	ctl_t ctl;

	sh256_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (msg.valid),
		.in_data       (msg.data_byte),
		.in_byte_valid (msg.byte_valid),
		.in_end        (msg.message_end),
		.in_ready      (msg.ready),
		.out_valid     (digest.valid),
		.out_ready     (digest.ready),
		.ctl           (ctl)
	);

	sh256_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.digest_word (digest.digest_word)
	);

	assign digest.word_index = ctl.out_idx;
	assign digest.last_word  = ctl.out_idx == LAST_WORD;

endmodule

[rtl/sh256_checker.sv]
// Port-level checks on the SHA-256 stream hasher, bound to the top level.
`timescale 1ns / 1ps
module sh256_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	a_no_intake_during_readout: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while digest pending");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
		else $error("digest word changed under stall");

	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> word_index == 3'd0 && !last_word)
		else $error("digest does not start at word 0");

	a_word_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=>
			out_valid && word_index == $past(word_index) + 3'd1)
		else $error("digest word sequence broken");

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_word |=> !out_valid && in_ready)
		else $error("no return to idle after last word");

endmodule

bind sha256_stream_hash sh256_checker u_sh256_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (msg.ready),
	.out_valid   (digest.valid),
	.out_ready   (digest.ready),
	.digest_word (digest.digest_word),
	.word_index  (digest.word_index),
	.last_word   (digest.last_word)
);
